/* rtl/tmc_pkg.sv */
package tmc_pkg;

  localparam int AtanEntries = 24;
  localparam int CordicStagesDefault = 16;
  localparam int AngW = 16;
  localparam int QW = 34;
  localparam int ZW = 34;
  localparam logic signed [QW-1:0] CordicGain = 34'sd652032874;
  localparam logic signed [19:0] RadPerUnit = 20'sd292818;
  localparam logic signed [AngW+1:0] HalfTurn = 18'sd11520;
  localparam logic signed [AngW+1:0] FullTurn = 18'sd23040;
  localparam logic signed [AngW+1:0] QuarterTurn = 18'sd5760;
  localparam logic signed [QW-1:0] OneQ30 = 34'sd1073741824;
  localparam logic [31:0] OneQ16 = 32'd65536;

  // CORDIC state handed from cell to cell.
  typedef struct packed {
    logic signed [QW-1:0] x;
    logic signed [QW-1:0] y;
    logic signed [ZW-1:0] z;
    logic neg;
  } cord_t;

  // Arctangent of 2^-i in Q4.30, truncated.
  function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] idx);
    logic signed [ZW-1:0] r;
    unique case (idx)
      5'd0: r = 34'sd843314856;  5'd1: r = 34'sd497837829;
      5'd2: r = 34'sd263043836;  5'd3: r = 34'sd133525158;
      5'd4: r = 34'sd67021686;   5'd5: r = 34'sd33543515;
      5'd6: r = 34'sd16775850;   5'd7: r = 34'sd8388437;
      5'd8: r = 34'sd4194282;    5'd9: r = 34'sd2097149;
      5'd10: r = 34'sd1048575;   5'd11: r = 34'sd524287;
      5'd12: r = 34'sd262143;    5'd13: r = 34'sd131071;
      5'd14: r = 34'sd65535;     5'd15: r = 34'sd32767;
      5'd16: r = 34'sd16383;     5'd17: r = 34'sd8191;
      5'd18: r = 34'sd4095;      5'd19: r = 34'sd2047;
      5'd20: r = 34'sd1023;      5'd21: r = 34'sd511;
      5'd22: r = 34'sd255;       5'd23: r = 34'sd127;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/tmc_cordic_cell.sv */
// One CORDIC micro-rotation; its register is one link in the chain.
module tmc_cordic_cell #(
  parameter int Stage = 0
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  tmc_pkg::cord_t   c_i,
  output tmc_pkg::cord_t   c_o
);

  tmc_pkg::cord_t c_d, c_q;
  logic signed [tmc_pkg::QW-1:0] dx, dy;

  // Arithmetic shift is floor, as required.
  assign dx = c_i.y >>> Stage;
  assign dy = c_i.x >>> Stage;

  always_comb begin
    c_d = c_i;
    if (!c_i.z[tmc_pkg::ZW-1]) begin
      c_d.x = c_i.x - dx;
      c_d.y = c_i.y + dy;
      c_d.z = c_i.z - tmc_pkg::atan_q30(5'(Stage));
    end else begin
      c_d.x = c_i.x + dx;
      c_d.y = c_i.y - dy;
      c_d.z = c_i.z + tmc_pkg::atan_q30(5'(Stage));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q <= c_d;
    end
  end

  assign c_o = c_q;

endmodule

/* rtl/tmc_sincos.sv */
// Angle fold, radian scaling and a chain of CORDIC cells for one angle.
module tmc_sincos #(
  parameter int CordicStages = tmc_pkg::CordicStagesDefault
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic signed [15:0]            angle_i,
  output logic signed [tmc_pkg::QW-1:0] sin_o,
  output logic signed [tmc_pkg::QW-1:0] cos_o
);

  logic signed [17:0] r0, r1;
  logic neg;
  tmc_pkg::cord_t chain [CordicStages+1];
  tmc_pkg::cord_t c_d, c_q;

  // Fold into [-90, 90] degrees; sine and cosine flip when folded.
  always_comb begin
    r0 = 18'(angle_i);
    if (r0 >= tmc_pkg::HalfTurn) begin
      r0 = r0 - tmc_pkg::FullTurn;
    end else if (r0 < -tmc_pkg::HalfTurn) begin
      r0 = r0 + tmc_pkg::FullTurn;
    end
    neg = 1'b0;
    r1 = r0;
    if (r0 > tmc_pkg::QuarterTurn) begin
      r1 = r0 - tmc_pkg::HalfTurn;
      neg = 1'b1;
    end else if (r0 < -tmc_pkg::QuarterTurn) begin
      r1 = r0 + tmc_pkg::HalfTurn;
      neg = 1'b1;
    end
    c_d.x = tmc_pkg::CordicGain;
    c_d.y = '0;
    c_d.z = tmc_pkg::ZW'(r1) * tmc_pkg::ZW'(tmc_pkg::RadPerUnit);
    c_d.neg = neg;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q <= c_d;
    end
  end

  assign chain[0] = c_q;

  for (genvar g = 0; g < CordicStages; g++) begin : g_cell
    tmc_cordic_cell #(.Stage(g)) u_cell (
      .clk_i(clk_i), .en_i(en_i), .c_i(chain[g]), .c_o(chain[g+1])
    );
  end

  assign cos_o = chain[CordicStages].neg ? -chain[CordicStages].x
                                         : chain[CordicStages].x;
  assign sin_o = chain[CordicStages].neg ? -chain[CordicStages].y
                                         : chain[CordicStages].y;

endmodule

/* rtl/trs_model_matrix_compose.sv */
// Channel | Direction | Beat contents
// in      | input     | scale_x/y/z, angle_x/y/z, shift_x/y/z
// out     | output    | row_index, col_index, entry_value, last_entry
//
// The sixteen-entry serializer on the output sets the pose rate, and it can
// stall on out_ready_i. The first beat follows the fold register, the CORDIC
// cells, stages 1 to 3 and the serializer register. Reset clears the pipeline
// valid bits and the serializer. Poses keep entering while the serializer
// works; the whole pipeline, input included, holds only while stage 3 has a
// matrix that the serializer cannot take yet.
module trs_model_matrix_compose #(
  parameter int CORDIC_STAGES = tmc_pkg::CordicStagesDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] scale_x_i,
  input  logic signed [31:0] scale_y_i,
  input  logic signed [31:0] scale_z_i,
  input  logic signed [15:0] angle_x_i,
  input  logic signed [15:0] angle_y_i,
  input  logic signed [15:0] angle_z_i,
  input  logic signed [31:0] shift_x_i,
  input  logic signed [31:0] shift_y_i,
  input  logic signed [31:0] shift_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         row_index_o,
  output logic [1:0]         col_index_o,
  output logic signed [31:0] entry_value_o,
  output logic               last_entry_o
);

  localparam int Depth = CORDIC_STAGES + 1;
  localparam int QW = tmc_pkg::QW;
  localparam int MW = 2 * QW;

  typedef logic signed [QW-1:0] q_t;
  typedef struct packed {
    logic signed [31:0] sx, sy, sz, tx, ty, tz;
  } side_t;

  logic en;
  logic [Depth-1:0] vld_q;
  side_t side_q [Depth];
  q_t sxv, cxv, syv, cyv, szv, czv;

  // Pipeline advances when stage 3 is empty or the post stage takes its matrix.
  logic post_full_q, post_take;
  logic s1_v_q, s2_v_q, s3_v_q;
  logic mat_free;

  // The whole pipeline holds when stage 3 is full and cannot drain.
  assign mat_free = !s3_v_q || post_take;
  assign en = mat_free;

  tmc_sincos #(.CordicStages(CORDIC_STAGES)) u_sx (
    .clk_i(clk_i), .en_i(en), .angle_i(angle_x_i), .sin_o(sxv), .cos_o(cxv));
  tmc_sincos #(.CordicStages(CORDIC_STAGES)) u_sy (
    .clk_i(clk_i), .en_i(en), .angle_i(angle_y_i), .sin_o(syv), .cos_o(cyv));
  tmc_sincos #(.CordicStages(CORDIC_STAGES)) u_sz (
    .clk_i(clk_i), .en_i(en), .angle_i(angle_z_i), .sin_o(szv), .cos_o(czv));

  assign in_ready_o = en;

  // Valid bits and side data follow the CORDIC chain.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= '{scale_x_i, scale_y_i, scale_z_i, shift_x_i, shift_y_i, shift_z_i};
      for (int k = 1; k < Depth; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // Stage 1: P = Ry*Rx products (products registered after one multiply).
  q_t p00, p01, p02, p11, p12, p20, p21, p22;
  q_t s1_sz, s1_cz;
  side_t s1_side;

  function automatic q_t m30(input q_t a, input q_t b);
    logic signed [MW-1:0] p;
    p = MW'(a) * MW'(b);
    return QW'(p >>> 30);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= vld_q[Depth-1];
    end
  end

  // P = Ry*Rx: [cy, -sy*sx, -sy*cx; 0, cx, -sx; sy, cy*sx, cy*cx]
  // (terms with one are exact: taken directly, with no multiply).
  always_ff @(posedge clk_i) begin
    if (en) begin
      p00 <= cyv;
      p01 <= m30(-syv, sxv);
      p02 <= m30(-syv, cxv);
      p11 <= cxv;
      p12 <= -sxv;
      p20 <= syv;
      p21 <= m30(cyv, sxv);
      p22 <= m30(cyv, cxv);
      s1_sz <= szv;
      s1_cz <= czv;
      s1_side <= side_q[Depth-1];
    end
  end

  // Stage 2: R = Rz*P. Row 2 equals row 2 of P.
  q_t r00, r01, r02, r10, r11, r12, r20, r21, r22;
  side_t s2_side;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (en) begin
      s2_v_q <= s1_v_q;
    end
  end

  // Zero-product terms vanish exactly; p10 is zero.
  always_ff @(posedge clk_i) begin
    if (en) begin
      r00 <= m30(s1_cz, p00);
      r01 <= m30(s1_cz, p01) + m30(-s1_sz, p11);
      r02 <= m30(s1_cz, p02) + m30(-s1_sz, p12);
      r10 <= m30(s1_sz, p00);
      r11 <= m30(s1_sz, p01) + m30(s1_cz, p11);
      r12 <= m30(s1_sz, p02) + m30(s1_cz, p12);
      r20 <= p20;
      r21 <= p21;
      r22 <= p22;
      s2_side <= s1_side;
    end
  end

  // Stage 3: scale columns and saturate.
  logic signed [31:0] m_q [9];
  side_t s3_side;

  function automatic logic signed [31:0] scl(input q_t e, input logic signed [31:0] s);
    logic signed [QW-1:0] ec;
    logic signed [QW+31:0] p;
    logic signed [QW+1:0] v;
    ec = e;
    if (e > 34'sd2147483648) ec = 34'sd2147483648;
    if (e < -34'sd2147483648) ec = -34'sd2147483648;
    p = (QW+32)'(ec) * (QW+32)'(s);
    v = (QW+2)'(p >>> 30);
    if (v > 36'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -36'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (en) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_q[0] <= scl(r00, s2_side.sx); m_q[1] <= scl(r01, s2_side.sy);
      m_q[2] <= scl(r02, s2_side.sz); m_q[3] <= scl(r10, s2_side.sx);
      m_q[4] <= scl(r11, s2_side.sy); m_q[5] <= scl(r12, s2_side.sz);
      m_q[6] <= scl(r20, s2_side.sx); m_q[7] <= scl(r21, s2_side.sy);
      m_q[8] <= scl(r22, s2_side.sz);
      s3_side <= s2_side;
    end
  end

  // Serializer: holds one matrix, emits sixteen beats.
  logic signed [31:0] h_q [12];
  logic [3:0] idx_q;
  logic beat_done;

  assign beat_done = out_valid_o && out_ready_i;
  assign post_take = s3_v_q && (!post_full_q || (beat_done && idx_q == 4'd15));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      post_full_q <= 1'b0;
      idx_q <= '0;
    end else begin
      if (beat_done) begin
        idx_q <= idx_q + 4'd1;
      end
      if (post_take) begin
        post_full_q <= 1'b1;
      end else if (beat_done && idx_q == 4'd15) begin
        post_full_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (post_take) begin
      h_q[0] <= m_q[0]; h_q[1] <= m_q[1]; h_q[2] <= m_q[2];  h_q[3] <= s3_side.tx;
      h_q[4] <= m_q[3]; h_q[5] <= m_q[4]; h_q[6] <= m_q[5];  h_q[7] <= s3_side.ty;
      h_q[8] <= m_q[6]; h_q[9] <= m_q[7]; h_q[10] <= m_q[8]; h_q[11] <= s3_side.tz;
    end
  end

  // Rows 0 to 2 sit at the entry number itself; row 3 is constant.
  assign out_valid_o = post_full_q;
  assign row_index_o = idx_q[3:2];
  assign col_index_o = idx_q[1:0];
  assign last_entry_o = (idx_q == 4'd15);
  assign entry_value_o = (idx_q[3:2] == 2'd3) ? ((idx_q[1:0] == 2'd3) ? tmc_pkg::OneQ16 : '0)
                                              : h_q[idx_q];

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_entry_o |-> (row_index_o == 2'd3 && col_index_o == 2'd3))
    else $error("last flag off the final entry");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> ($stable(idx_q) && out_valid_o))
    else $error("serializer moved while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_v_q && !post_take) |-> !en)
    else $error("pipeline advanced over a held matrix");

endmodule
